[rtl/core/rc_packet_failsafe_hopper_macros.svh]
// Assertion macros for the radio receiver core.
// Expects clk and rst in the scope where a macro is used.
`ifndef RC_PACKET_FAILSAFE_HOPPER_MACROS_SVH
`define RC_PACKET_FAILSAFE_HOPPER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RCFH_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rcfh assertion failed");

// Next-cycle implication, checked outside reset
`define RCFH_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rcfh assertion failed");

`endif

[rtl/core/rcfh_pkg.sv]
// Shared types, constants and the hop table for the radio receiver core.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package rcfh_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int CHAN_W   = 10;
  localparam int MODE_W   = 13;
  localparam int HOP_W    = 3;
  localparam int MISS_W   = 8;
  localparam int LOSS_W   = 16;
  localparam int HOPT_W   = 8;
  localparam int CFG_W    = 16;

  // Sizes
  localparam int CHANNEL_COUNT   = 8;
  localparam int STORE_LEN       = 11;
  localparam int CNT_W           = $clog2(STORE_LEN + 1);
  localparam int HOP_SLOTS       = 5;
  localparam int HOP_TABLE_DEPTH = 100;
  localparam int RND_PTR_W       = $clog2(HOP_TABLE_DEPTH + 1);
  localparam int RND_TAB_LEN     = 100;
  localparam int RND_IDX_W       = $clog2(RND_TAB_LEN);
  localparam int RND_ARG_W       = 9;

  // Headers and reset values
  localparam logic [BYTE_W-1:0] HDR_FAILSAFE = 8'ha0;
  localparam logic [BYTE_W-1:0] HDR_LIVE     = 8'ha1;
  localparam logic [BYTE_W-1:0] HDR_MODE     = 8'ha2;
  localparam logic [LOSS_W-1:0] LOSS_TIMEOUT_RESET = 16'd2000;
  localparam logic [HOPT_W-1:0] HOP_PERIOD_RESET   = 8'd24;
  localparam logic [CHAN_W-1:0] CHAN_RESET         = 10'd511;
  localparam logic [CHAN_W-1:0] FS_CH2_RESET       = 10'd80;
  localparam int                FS_CH2_IDX         = 2;
  localparam logic [MISS_W-1:0] MISS_LIMIT         = 8'd5;
  localparam logic [MISS_W-1:0] MISS_MAX           = 8'd255;

  // Command and register codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic CFG_LOSS_TIMEOUT = 1'b0;
  localparam logic CFG_HOP_PERIOD   = 1'b1;

  typedef enum logic [1:0] {
    EV_PACKET = 2'd0,
    EV_HOP    = 2'd1,
    EV_LOST   = 2'd2
  } ev_t;

  typedef logic [CHANNEL_COUNT-1:0][CHAN_W-1:0] chan_vec_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    ev_t               event_res;
    logic [HOP_W-1:0]  hop_index;
    logic              failsafe_active;
    logic [MODE_W-1:0] mode_word;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;
    logic [CHAN_W-1:0] chan4;
    logic [CHAN_W-1:0] chan5;
    logic [CHAN_W-1:0] chan6;
    logic [CHAN_W-1:0] chan7;
  } out_t;

  // One processing step of the registered request
  typedef struct packed {
    logic              en;
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic              last_byte;
  } step_t;

  typedef struct packed {
    logic             we;
    logic             index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  // Finished packet, decoded from the store plus the final byte
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] hdr;
    logic [MODE_W-1:0] mode;
    chan_vec_t         vals;
  } pkt_t;

  // Link status after this step
  typedef struct packed {
    logic             lost;
    logic             hopped;
    logic [HOP_W-1:0] hop_pos;
    logic             fs_flag;
  } link_stat_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    chan_vec_t         live;
  } chan_view_t;

  localparam logic [HOP_W-1:0] RND_TAB [RND_TAB_LEN] = '{
    3'd4,3'd1,3'd3,3'd2,3'd2,3'd1,3'd0,3'd0,3'd2,3'd2,3'd2,3'd3,3'd4,3'd1,3'd2,3'd1,3'd4,
    3'd3,3'd3,3'd4,3'd2,3'd0,3'd2,3'd2,3'd3,3'd1,3'd2,3'd3,3'd2,3'd2,3'd2,3'd4,3'd2,3'd4,
    3'd0,3'd3,3'd4,3'd2,3'd3,3'd1,3'd0,3'd3,3'd1,3'd3,3'd3,3'd0,3'd2,3'd0,3'd4,3'd3,3'd3,
    3'd3,3'd3,3'd3,3'd4,3'd1,3'd1,3'd4,3'd3,3'd0,3'd1,3'd0,3'd3,3'd2,3'd3,3'd2,3'd3,
    3'd3,3'd4,3'd4,3'd1,3'd3,3'd0,3'd0,3'd3,3'd1,3'd3,3'd3,3'd3,3'd0,3'd3,3'd3,3'd4,
    3'd1,3'd2,3'd4,3'd1,3'd3,3'd0,3'd1,3'd3,3'd4,3'd4,3'd3,3'd2,3'd3,3'd1,3'd2,3'd3,3'd3
  };

  // Pseudo-random hop slot; entries past the table read as zero
  function automatic logic [HOP_W-1:0] rnd_slot(input logic [RND_ARG_W-1:0] idx);
    logic [HOP_W-1:0] slot;
    slot = '0;
    if (idx < RND_ARG_W'(RND_TAB_LEN)) begin
      slot = RND_TAB[idx[RND_IDX_W-1:0]];
    end
    return slot;
  endfunction

  // Step the hop slot, wrapping after the last one
  function automatic logic [HOP_W-1:0] hop_step(input logic [HOP_W-1:0] pos);
    logic [HOP_W-1:0] nxt;
    nxt = pos + HOP_W'(1);
    if (nxt >= HOP_W'(HOP_SLOTS)) begin
      nxt = '0;
    end
    return nxt;
  endfunction

endpackage

[rtl/core/rcfh_packet_asm.sv]
// Packet assembly: byte store, byte count and unpacking of a finished packet.
// Depends on rcfh_pkg.
`timescale 1ns / 1ps

module rcfh_packet_asm (
  input  logic          clk,
  input  logic          rst,
  input  rcfh_pkg::step_t step,
  output rcfh_pkg::pkt_t  pkt
);
  import rcfh_pkg::*;

  logic [STORE_LEN-1:0][BYTE_W-1:0] store;
  logic [STORE_LEN-1:0][BYTE_W-1:0] view;
  logic [CNT_W-1:0]                 byte_count;
  logic                             byte_wr;

  assign byte_wr = step.en && (step.cmd == CMD_BYTE);

  // Overlay the incoming byte on the store at the fill position
  always_comb begin
    for (int i = 0; i < STORE_LEN; i++) begin
      view[i] = (byte_wr && (byte_count == CNT_W'(i))) ? step.rx_byte : store[i];
    end
  end

  // Unpack the mode word and two groups of four 10-bit values
  always_comb begin
    pkt.done = byte_wr && step.last_byte;
    pkt.hdr  = view[0];
    pkt.mode = {view[1][7:6], view[1][3:1], view[2]};
    for (int h = 0; h < 2; h++) begin
      pkt.vals[4*h]   = {view[1+5*h],       view[2+5*h][7:6]};
      pkt.vals[4*h+1] = {view[2+5*h][5:0],  view[3+5*h][7:4]};
      pkt.vals[4*h+2] = {view[3+5*h][3:0],  view[4+5*h][7:2]};
      pkt.vals[4*h+3] = {view[4+5*h][1:0],  view[5+5*h]};
    end
  end

  // Store bytes; drop extras; clear after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      store      <= '0;
      byte_count <= '0;
    end else if (byte_wr) begin
      if (step.last_byte) begin
        store      <= '0;
        byte_count <= '0;
      end else begin
        store <= view;
        if (byte_count < CNT_W'(STORE_LEN)) begin
          byte_count <= byte_count + CNT_W'(1);
        end
      end
    end
  end

endmodule

[rtl/core/rcfh_link_ctrl.sv]
// Link control: loss and hop timers, miss count, hop index and failsafe flag.
// Holds the two configuration registers. Depends on rcfh_pkg.
`timescale 1ns / 1ps

module rcfh_link_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  rcfh_pkg::cfg_wr_t    cfg,
  input  rcfh_pkg::step_t      step,
  output rcfh_pkg::link_stat_t stat
);
  import rcfh_pkg::*;

  logic [LOSS_W-1:0]    loss_timeout;
  logic [HOPT_W-1:0]    hop_period;
  logic [LOSS_W-1:0]    loss_timer, loss_timer_next;
  logic                 loss_armed, loss_armed_next;
  logic [HOPT_W-1:0]    hop_timer, hop_timer_next;
  logic                 hop_running, hop_running_next;
  logic [MISS_W-1:0]    miss_count, miss_count_next;
  logic [RND_PTR_W-1:0] rnd_ptr, rnd_ptr_next;
  logic [HOP_W-1:0]     hop_pos, hop_pos_next;
  logic                 fs_flag, fs_flag_next;
  logic                 lost, hopped;

  // Work out the next link state for a packet end or a tick
  always_comb begin
    logic [LOSS_W-1:0]    loss_inc;
    logic [HOPT_W-1:0]    hop_inc;
    logic [MISS_W-1:0]    miss_sat;
    logic [RND_PTR_W-1:0] ptr_use;
    loss_timer_next  = loss_timer;
    loss_armed_next  = loss_armed;
    hop_timer_next   = hop_timer;
    hop_running_next = hop_running;
    miss_count_next  = miss_count;
    rnd_ptr_next     = rnd_ptr;
    hop_pos_next     = hop_pos;
    fs_flag_next     = fs_flag;
    lost             = 1'b0;
    hopped           = 1'b0;
    loss_inc = loss_timer + LOSS_W'(1);
    hop_inc  = hop_timer + HOPT_W'(1);
    miss_sat = (miss_count == MISS_MAX) ? miss_count : miss_count + MISS_W'(1);
    ptr_use  = (rnd_ptr >= RND_PTR_W'(HOP_TABLE_DEPTH)) ? '0 : rnd_ptr;
    if (step.en && (step.cmd == CMD_BYTE) && step.last_byte) begin
      miss_count_next  = '0;
      fs_flag_next     = 1'b0;
      loss_timer_next  = '0;
      loss_armed_next  = 1'b1;
      hop_timer_next   = '0;
      hop_running_next = 1'b1;
      hop_pos_next     = hop_step(hop_pos);
    end else if (step.en && (step.cmd == CMD_TICK)) begin
      // One-shot loss timeout
      if (loss_armed) begin
        loss_timer_next = loss_inc;
        if (loss_inc >= loss_timeout) begin
          loss_armed_next = 1'b0;
          loss_timer_next = '0;
          fs_flag_next    = 1'b1;
          lost            = 1'b1;
        end
      end
      // Periodic hop timer
      if (hop_running) begin
        hop_timer_next = hop_inc;
        if (hop_inc >= hop_period) begin
          hop_timer_next  = '0;
          miss_count_next = miss_sat;
          hopped          = 1'b1;
          if (miss_sat > MISS_LIMIT) begin
            hop_pos_next = rnd_slot(RND_ARG_W'(ptr_use));
            rnd_ptr_next = ptr_use + RND_PTR_W'(1);
          end else begin
            hop_pos_next = hop_step(hop_pos);
          end
        end
      end
    end
  end

  always_comb begin
    stat.lost    = lost;
    stat.hopped  = hopped;
    stat.hop_pos = hop_pos_next;
    stat.fs_flag = fs_flag_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_timeout <= LOSS_TIMEOUT_RESET;
      hop_period   <= HOP_PERIOD_RESET;
    end else if (cfg.we) begin
      if (cfg.index == CFG_LOSS_TIMEOUT) begin
        loss_timeout <= cfg.data[LOSS_W-1:0];
      end else begin
        hop_period <= cfg.data[HOPT_W-1:0];
      end
    end
  end

  // Link state
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_timer  <= '0;
      loss_armed  <= 1'b0;
      hop_timer   <= '0;
      hop_running <= 1'b0;
      miss_count  <= '0;
      rnd_ptr     <= '0;
      hop_pos     <= '0;
      fs_flag     <= 1'b0;
    end else begin
      loss_timer  <= loss_timer_next;
      loss_armed  <= loss_armed_next;
      hop_timer   <= hop_timer_next;
      hop_running <= hop_running_next;
      miss_count  <= miss_count_next;
      rnd_ptr     <= rnd_ptr_next;
      hop_pos     <= hop_pos_next;
      fs_flag     <= fs_flag_next;
    end
  end

endmodule

[rtl/core/rcfh_chan_regs.sv]
// Channel registers: live values, failsafe values and the mode word.
// Depends on rcfh_pkg.
`timescale 1ns / 1ps

module rcfh_chan_regs (
  input  logic                clk,
  input  logic                rst,
  input  rcfh_pkg::pkt_t       pkt,
  input  logic                lost,
  output rcfh_pkg::chan_view_t view
);
  import rcfh_pkg::*;

  chan_vec_t         live, live_next;
  chan_vec_t         failsafe, failsafe_next;
  logic [MODE_W-1:0] mode, mode_next;

  // Load from a packet by header, or copy failsafe values on loss
  always_comb begin
    live_next     = live;
    failsafe_next = failsafe;
    mode_next     = mode;
    if (pkt.done) begin
      if (pkt.hdr == HDR_MODE) begin
        mode_next = pkt.mode;
      end else if (pkt.hdr == HDR_FAILSAFE) begin
        failsafe_next = pkt.vals;
      end else if (pkt.hdr == HDR_LIVE) begin
        live_next = pkt.vals;
      end
    end else if (lost) begin
      live_next = failsafe;
    end
  end

  always_comb begin
    view.mode = mode_next;
    view.live = live_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        live[i]     <= CHAN_RESET;
        failsafe[i] <= (i == FS_CH2_IDX) ? FS_CH2_RESET : CHAN_RESET;
      end
      mode <= '0;
    end else begin
      live     <= live_next;
      failsafe <= failsafe_next;
      mode     <= mode_next;
    end
  end

endmodule

[rtl/core/rc_packet_failsafe_hopper.sv]
// Radio receiver core top level: input register, state units, result register.
// Depends on rcfh_pkg, rcfh_packet_asm, rcfh_link_ctrl, rcfh_chan_regs and the macro header.
//
// Usage:
//   in_valid/in_ready/in_data carry one request: a packet byte (cmd = 0, with
//   last_byte marking the end of a packet) or a millisecond tick (cmd = 1).
//   out_valid/out_ready/out_data carry a result: one per finished packet, and
//   one per tick on which the hop timer or the loss timer expires.
//   cfg_we/cfg_index/cfg_data write loss_timeout_ms (index 0) and
//   hop_period_ms (index 1); write only while the block is idle.
// Timing:
//   A request taken into the input register is processed once the result
//   register is free; its result loads into that register. One request per
//   cycle is sustained if out_ready holds; state updates in one registered pass.
// Reset (rst, synchronous): timers stop, hop index 0, live channels 511,
//   failsafe values 511 except channel 2 at 80, mode word 0, both
//   configuration registers at their defaults.
// Stall: while a result waits on out_ready, one more request is held in the
//   input register and in_ready then drops until the result is taken.
`timescale 1ns / 1ps
`include "rc_packet_failsafe_hopper_macros.svh"

module rc_packet_failsafe_hopper (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rcfh_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rcfh_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);
  import rcfh_pkg::*;

  logic       in_valid_q;
  in_t        in_q;
  logic       fire;
  logic       produces;
  logic       out_valid_q;
  out_t       out_q;
  out_t       result;
  step_t      step;
  cfg_wr_t    cfg;
  pkt_t       pkt;
  link_stat_t stat;
  chan_view_t chans;

  // Process the held request when the result register is free
  assign fire     = in_valid_q && (!out_valid_q || out_ready);
  assign in_ready = !in_valid_q || fire;

  always_comb begin
    step.en        = fire;
    step.cmd       = in_q.cmd;
    step.rx_byte   = in_q.rx_byte;
    step.last_byte = in_q.last_byte;
    cfg.we         = cfg_we;
    cfg.index      = cfg_index;
    cfg.data       = cfg_data;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  rcfh_packet_asm u_packet_asm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .pkt  (pkt)
  );

  rcfh_link_ctrl u_link_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .stat (stat)
  );

  rcfh_chan_regs u_chan_regs (
    .clk  (clk),
    .rst  (rst),
    .pkt  (pkt),
    .lost (stat.lost),
    .view (chans)
  );

  // Assemble the result from the updated state
  always_comb begin
    produces = (in_q.cmd == CMD_BYTE) ? in_q.last_byte : (stat.lost || stat.hopped);
    if (in_q.cmd == CMD_BYTE) begin
      result.event_res = EV_PACKET;
    end else if (stat.lost) begin
      result.event_res = EV_LOST;
    end else begin
      result.event_res = EV_HOP;
    end
    result.hop_index       = stat.hop_pos;
    result.failsafe_active = stat.fs_flag;
    result.mode_word       = chans.mode;
    result.chan0           = chans.live[0];
    result.chan1           = chans.live[1];
    result.chan2           = chans.live[2];
    result.chan3           = chans.live[3];
    result.chan4           = chans.live[4];
    result.chan5           = chans.live[5];
    result.chan6           = chans.live[6];
    result.chan7           = chans.live[7];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (fire && produces) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produces) begin
      out_q <= result;
    end
  end

  assign out_valid = out_valid_q;
  assign out_data  = out_q;

  // A processed request that yields a result shows up next cycle
  `RCFH_ASSERT_NEXT(a_result_loaded, fire && produces, out_valid_q && (out_q == $past(result)))
  // A finished packet always reports a packet event with failsafe cleared
  `RCFH_ASSERT_NEXT(a_packet_clears_fs, fire && (in_q.cmd == CMD_BYTE) && in_q.last_byte,
    (out_q.event_res == EV_PACKET) && !out_q.failsafe_active)
  // Loss and hop events come only from a processed tick
  `RCFH_ASSERT_NOW(a_timer_on_tick, stat.lost || stat.hopped, fire && (in_q.cmd == CMD_TICK))
  // A held request waits unchanged in the input register
  `RCFH_ASSERT_NEXT(a_input_held, in_valid_q && !fire, in_valid_q && $stable(in_q))

endmodule
